// File: hw/rtl/bct_pkg.sv
package bct_pkg;

	localparam int ENTRIES     = 64;
	localparam int STATUS_BITS = 8;
	localparam int HIT_W       = 64;
	localparam int PORT_W      = 16;
	localparam int OP_W        = 2;
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int PH_W        = $clog2(ENTRIES + 1);

	// first-hit search is split into groups of cells
	localparam int GROUP   = 8;
	localparam int NGROUPS = (ENTRIES + GROUP - 1) / GROUP;

	// beat widths
	localparam int IN_W  = 304;
	localparam int OUT_W = 32;

	// input beat field offsets
	localparam int OFS_OP     = 0;
	localparam int OFS_SRC_HI = 2;
	localparam int OFS_SRC_LO = 66;
	localparam int OFS_DST_HI = 130;
	localparam int OFS_DST_LO = 194;
	localparam int OFS_SPORT  = 258;
	localparam int OFS_DPORT  = 274;
	localparam int OFS_STATUS = 290;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] RC_OK       = 2'd0;
	localparam logic [1:0] RC_FULL     = 2'd1;
	localparam logic [1:0] RC_NOTFOUND = 2'd2;

	typedef logic [STATUS_BITS-1:0] status_t;

	typedef struct packed {
		logic [HIT_W-1:0]  src_hi;
		logic [HIT_W-1:0]  src_lo;
		logic [HIT_W-1:0]  dst_hi;
		logic [HIT_W-1:0]  dst_lo;
		logic [PORT_W-1:0] sport;
		logic [PORT_W-1:0] dport;
		status_t           status;
	} entry_t;

	typedef struct packed {
		logic write;   // load the key into this cell
		logic cmp;     // register match flags against the key
		logic valid;   // cell lies below the entry count
		logic take_l;  // swap with left neighbor
		logic take_r;  // swap with right neighbor
	} cell_ctrl_t;

	typedef struct packed {
		logic    hit;
		logic    rev;
		status_t status;
	} grp_res_t;

endpackage

// File: hw/rtl/bidirectional_connection_table.sv
// Bidirectional connection table. Holds up to ENTRIES (64) connections in
// insertion order, one per cell of a row of identical cells; each cell keeps
// two 128-bit host identifiers, two 16-bit ports and a status, and compares
// itself against the incoming key in parallel. Every input beat carries one
// command (add, lookup, delete, clear) and produces exactly one result beat.
// Add appends without a duplicate check and reports full when no slot is
// free. Lookup returns the first entry matching forward or with source and
// destination swapped (forward wins), in a registered compare followed by a
// registered first-hit search over groups of eight cells. Delete marks every
// matching entry and closes the gaps by odd-even swaps between neighboring
// cells, which bubble the marked entries to the tail while keeping the order
// of the survivors. After acceptance, add and clear go straight to their result
// state; lookup passes through compare, group search and result selection, and
// delete through compare, the swap phases of the cell row and result. One command
// is worked on at a time; the input is taken again as soon as the previous
// command has handed its result to the output register, even while that
// beat still waits for the sink. The table needs no clearing pass after
// reset: only cells below the entry count are ever read.
module bidirectional_connection_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// op[1:0], src_hit_high[65:2], src_hit_low[129:66], dst_hit_high[193:130],
	// dst_hit_low[257:194], local_port[273:258], peer_port[289:274],
	// new_status[297:290], zero fill [303:298]
	input  logic [bct_pkg::IN_W-1:0] s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// result_code[1:0], found_status[9:2], reversed[10], removed_count[17:11],
	// used_entries[24:18], zero fill [31:25]
	output logic [bct_pkg::OUT_W-1:0] m_axis_tdata
);
	import bct_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_CLR  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_GRP  = 3'd4;
	localparam logic [2:0] ST_LKP  = 3'd5;
	localparam logic [2:0] ST_SORT = 3'd6;
	localparam logic [2:0] ST_DEL  = 3'd7;

	logic [2:0]       state_q;
	logic [OP_W-1:0]  op_q;
	entry_t           key_q;
	logic [CNT_W-1:0] count_q;
	logic [PH_W-1:0]  ph_q;
	logic [ENTRIES-1:0] sr_q;
	logic [CNT_W-1:0] rem_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic             out_free;
	logic             out_load;
	logic [1:0]       res_code;
	logic [7:0]       res_status;
	logic             res_rev;
	logic [CNT_W-1:0] res_removed;
	logic [CNT_W-1:0] res_used;
	logic             full;

	// cell row wiring
	entry_t           cell_entry [ENTRIES];
	logic [ENTRIES-1:0] cell_hole;
	logic [ENTRIES-1:0] cell_valid;
	logic [ENTRIES-1:0] swap;
	cell_ctrl_t       cell_ctrl [ENTRIES];

	// padded to whole groups for the first-hit search
	logic [NGROUPS*GROUP-1:0] hit_fwd;
	logic [NGROUPS*GROUP-1:0] hit_rev;
	status_t [NGROUPS*GROUP-1:0] hit_stat;
	grp_res_t         grp_res [NGROUPS];
	grp_res_t         lkp;

	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign full          = (count_q >= CNT_W'(ENTRIES));

	// swap[i] exchanges cells i and i+1: a marked entry moves one place
	// toward the tail past a surviving one; pairs alternate with the phase
	generate
		for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
			localparam logic PAR = 1'(i % 2);
			entry_t l_entry;
			entry_t r_entry;
			logic   l_hole;
			logic   r_hole;

			assign cell_valid[i] = CNT_W'(i) < count_q;

			if (i < ENTRIES - 1) begin : g_swap
				assign swap[i] = (state_q == ST_SORT) && (ph_q[0] == PAR) &&
				                 cell_hole[i] && !cell_hole[i+1] && cell_valid[i+1];
				assign r_entry = cell_entry[i+1];
				assign r_hole  = cell_hole[i+1];
			end else begin : g_last
				assign swap[i] = 1'b0;
				assign r_entry = cell_entry[i];
				assign r_hole  = cell_hole[i];
			end

			if (i > 0) begin : g_left
				assign l_entry            = cell_entry[i-1];
				assign l_hole             = cell_hole[i-1];
				assign cell_ctrl[i].take_l = swap[i-1];
			end else begin : g_first
				assign l_entry            = cell_entry[i];
				assign l_hole             = cell_hole[i];
				assign cell_ctrl[i].take_l = 1'b0;
			end

			assign cell_ctrl[i].take_r = swap[i];
			assign cell_ctrl[i].valid  = cell_valid[i];
			assign cell_ctrl[i].cmp    = (state_q == ST_CMP);
			assign cell_ctrl[i].write  = (state_q == ST_ADD) && out_free && !full &&
			                             (count_q == CNT_W'(i));

			bct_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (cell_ctrl[i]),
				.key         (key_q),
				.left_entry  (l_entry),
				.left_hole   (l_hole),
				.right_entry (r_entry),
				.right_hole  (r_hole),
				.entry       (cell_entry[i]),
				.hole        (cell_hole[i]),
				.fwd         (hit_fwd[i]),
				.rev         (hit_rev[i])
			);

			assign hit_stat[i] = cell_entry[i].status;
		end

		for (genvar i = ENTRIES; i < NGROUPS * GROUP; i++) begin : g_pad
			assign hit_fwd[i]  = 1'b0;
			assign hit_rev[i]  = 1'b0;
			assign hit_stat[i] = '0;
		end

		for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
			bct_group u_group (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (state_q == ST_GRP),
				.hit_fwd (hit_fwd[g*GROUP +: GROUP]),
				.hit_rev (hit_rev[g*GROUP +: GROUP]),
				.stat    (hit_stat[g*GROUP +: GROUP]),
				.res     (grp_res[g])
			);
		end
	endgenerate

	// first group with a hit
	always_comb begin
		lkp = '0;
		for (int g = NGROUPS - 1; g >= 0; g--) begin
			if (grp_res[g].hit) begin
				lkp = grp_res[g];
			end
		end
	end

	// result of the command finishing this cycle
	always_comb begin
		out_load    = 1'b0;
		res_code    = RC_OK;
		res_status  = '0;
		res_rev     = 1'b0;
		res_removed = '0;
		res_used    = count_q;
		case (state_q)
			ST_ADD: begin
				out_load = out_free;
				if (full) begin
					res_code = RC_FULL;
				end else begin
					res_used = count_q + CNT_W'(1);
				end
			end
			ST_CLR: begin
				out_load    = out_free;
				res_removed = count_q;
				res_used    = '0;
			end
			ST_LKP: begin
				out_load = out_free;
				if (lkp.hit) begin
					res_status = 8'(lkp.status);
					res_rev    = lkp.rev;
				end else begin
					res_code = RC_NOTFOUND;
				end
			end
			ST_DEL: begin
				out_load    = out_free;
				res_removed = rem_q;
				res_used    = count_q - rem_q;
				if (rem_q == '0) begin
					res_code = RC_NOTFOUND;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// hold the key of the command in progress
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			key_q.src_hi <= s_axis_tdata[OFS_SRC_HI +: HIT_W];
			key_q.src_lo <= s_axis_tdata[OFS_SRC_LO +: HIT_W];
			key_q.dst_hi <= s_axis_tdata[OFS_DST_HI +: HIT_W];
			key_q.dst_lo <= s_axis_tdata[OFS_DST_LO +: HIT_W];
			key_q.sport  <= s_axis_tdata[OFS_SPORT +: PORT_W];
			key_q.dport  <= s_axis_tdata[OFS_DPORT +: PORT_W];
			key_q.status <= s_axis_tdata[OFS_STATUS +: STATUS_BITS];
		end
	end

	// sequencer, entry count and delete bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_ADD;
			count_q <= '0;
			ph_q    <= '0;
			sr_q    <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= s_axis_tdata[OFS_OP +: OP_W];
						case (s_axis_tdata[OFS_OP +: OP_W])
							OP_ADD:   state_q <= ST_ADD;
							OP_CLEAR: state_q <= ST_CLR;
							default:  state_q <= ST_CMP;
						endcase
					end
				end
				ST_ADD: begin
					if (out_free) begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CLR: begin
					if (out_free) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_CMP: begin
					ph_q <= '0;
					if (op_q == OP_DELETE) begin
						state_q <= ST_SORT;
					end else begin
						state_q <= ST_GRP;
					end
				end
				ST_GRP: begin
					state_q <= ST_LKP;
				end
				ST_LKP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SORT: begin
					// snapshot the marks on the first phase, then count them
					// one per phase while the swaps run
					if (ph_q == '0) begin
						sr_q  <= cell_hole;
						rem_q <= '0;
					end else begin
						sr_q  <= sr_q >> 1;
						rem_q <= rem_q + CNT_W'(sr_q[0]);
					end
					if (ph_q == PH_W'(ENTRIES)) begin
						state_q <= ST_DEL;
					end else begin
						ph_q <= ph_q + PH_W'(1);
					end
				end
				ST_DEL: begin
					if (out_free) begin
						count_q <= count_q - rem_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {7'd0, 7'(res_used), 7'(res_removed), res_rev, res_status,
			              res_code};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

// File: hw/rtl/bct_cell.sv
module bct_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bct_pkg::cell_ctrl_t ctrl,
	input  bct_pkg::entry_t     key,
	input  bct_pkg::entry_t     left_entry,
	input  logic                left_hole,
	input  bct_pkg::entry_t     right_entry,
	input  logic                right_hole,
	output bct_pkg::entry_t     entry,
	output logic                hole,
	output logic                fwd,
	output logic                rev
);
	import bct_pkg::*;

	entry_t entry_q;
	logic   hole_q;
	logic   fwd_q;
	logic   rev_q;
	logic   m_fwd;
	logic   m_rev;

	assign m_fwd = entry_q.src_hi == key.src_hi && entry_q.src_lo == key.src_lo &&
	               entry_q.dst_hi == key.dst_hi && entry_q.dst_lo == key.dst_lo &&
	               entry_q.sport == key.sport && entry_q.dport == key.dport;
	assign m_rev = entry_q.dst_hi == key.src_hi && entry_q.dst_lo == key.src_lo &&
	               entry_q.src_hi == key.dst_hi && entry_q.src_lo == key.dst_lo &&
	               entry_q.dport == key.sport && entry_q.sport == key.dport;

	always_ff @(posedge clk) begin
		if (ctrl.write) begin
			entry_q <= key;
		end else if (ctrl.take_r) begin
			entry_q <= right_entry;
		end else if (ctrl.take_l) begin
			entry_q <= left_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= 1'b0;
			fwd_q  <= 1'b0;
			rev_q  <= 1'b0;
		end else if (ctrl.cmp) begin
			// forward match wins over swapped
			fwd_q  <= ctrl.valid & m_fwd;
			rev_q  <= ctrl.valid & ~m_fwd & m_rev;
			hole_q <= ctrl.valid & (m_fwd | m_rev);
		end else if (ctrl.take_r) begin
			hole_q <= right_hole;
		end else if (ctrl.take_l) begin
			hole_q <= left_hole;
		end
	end

	assign entry = entry_q;
	assign hole  = hole_q;
	assign fwd   = fwd_q;
	assign rev   = rev_q;

endmodule

// File: hw/rtl/bct_group.sv
module bct_group (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [bct_pkg::GROUP-1:0]           hit_fwd,
	input  logic [bct_pkg::GROUP-1:0]           hit_rev,
	input  bct_pkg::status_t [bct_pkg::GROUP-1:0] stat,
	output bct_pkg::grp_res_t                   res
);
	import bct_pkg::*;

	grp_res_t res_q;
	grp_res_t first;

	// lowest index wins: scan downward so the last assignment is the first hit
	always_comb begin
		first = '0;
		for (int k = GROUP - 1; k >= 0; k--) begin
			if (hit_fwd[k] || hit_rev[k]) begin
				first.hit    = 1'b1;
				first.rev    = hit_rev[k];
				first.status = stat[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (en) begin
			res_q <= first;
		end
	end

	assign res = res_q;

endmodule
